// ===== rtl/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg: shared types and codes for the sorted list table
// Item structs, operation and status codes, cell control and flag structs.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_KEY_WIDTH   = 32;

  // operation codes
  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_DELETE  = 3'd1;
  localparam logic [2:0] OP_SEARCH  = 3'd2;
  localparam logic [2:0] OP_REWIND  = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_END       = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] key_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] key_out;
    logic [3:0]         position;
    logic [4:0]         entry_count;
  } out_item_t;

  // shift commands broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctrl_t;

  // per-cell compare results
  typedef struct packed {
    logic after;  // empty, or key greater than the argument
    logic ge;     // held and key not below the argument
    logic eq;     // held and key equal to the argument
  } cell_flags_t;

endpackage

`default_nettype wire

// ===== rtl/slt_cell.sv =====
// ----------------------------------------------------------------------------
// slt_cell: one slot of the sorted table
// Holds one key, compares it with the broadcast argument and shifts toward
// either neighbor on insert or delete.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_cell #(
  parameter int KEY_WIDTH = slt_pkg::DEF_KEY_WIDTH
) (
  input  wire                           clk,
  input  wire slt_pkg::cell_ctrl_t      ctrl,
  input  wire logic signed [KEY_WIDTH-1:0] key_arg,
  input  wire logic signed [KEY_WIDTH-1:0] left_key,
  input  wire logic                     left_after,
  input  wire logic signed [KEY_WIDTH-1:0] right_key,
  input  wire logic                     valid,
  output logic signed [KEY_WIDTH-1:0]   key,
  output slt_pkg::cell_flags_t          flags
);

  always_comb begin
    flags.after = !valid || (key > key_arg);
    flags.ge    = valid && (key >= key_arg);
    flags.eq    = valid && (key == key_arg);
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      // open a gap: take the left key past the insert point, the new key at it
      if (left_after) begin
        key <= left_key;
      end else if (flags.after) begin
        key <= key_arg;
      end
    end else if (ctrl.del && flags.ge) begin
      // close the gap from the first match on
      key <= right_key;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_list_table.sv =====
// ----------------------------------------------------------------------------
// sorted_list_table: bounded table of signed keys in ascending order
// Insert, delete, search, rewind and read-next on a row of shifting cells.
//
//   channel  signals                        payload
//   in       in_valid / in_ready / in_data  opcode, key_in
//   out      out_valid / out_ready / out_data  status, key_out, position,
//                                              entry_count
//
// One item per cycle: every cell compares its key with the argument in the
// accept cycle and the whole row shifts at that edge; the result is
// registered at the same edge, so out_valid is high from the next cycle on.
// Reset empties the table and rewinds the cursor; no clearing pass.
// A stalled output holds its result; input is taken whenever the output
// register is empty or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_table #(
  parameter int TABLE_DEPTH = slt_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = slt_pkg::DEF_KEY_WIDTH
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire slt_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output slt_pkg::out_item_t      out_data
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);

  logic [CW-1:0] count;
  logic [CW-1:0] cursor;

  logic                        take;
  logic signed [63:0]          key_wide;
  logic signed [KEY_WIDTH-1:0] key_arg;
  slt_pkg::cell_ctrl_t         ctrl;

  logic signed [KEY_WIDTH-1:0] cell_key   [TABLE_DEPTH];
  slt_pkg::cell_flags_t        cell_flags [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]      cell_valid;
  logic [TABLE_DEPTH-1:0]      first_ge;

  logic                        found;
  logic [IW-1:0]               match_pos;
  logic signed [KEY_WIDTH-1:0] read_key;
  logic                        full;
  logic                        can_read;
  logic                        is_ins;
  logic                        is_del;
  logic                        is_srch;
  logic                        is_rew;
  logic                        is_read;

  logic [CW-1:0]               count_next;
  logic [CW-1:0]               cursor_next;
  logic [1:0]                  status_next;
  logic signed [63:0]          kout_wide;
  logic [IW-1:0]               pos_next;
  logic [63:0]                 pos_ext;
  logic [63:0]                 count_ext;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  assign key_wide = 64'(in_data.key_in);
  assign key_arg  = key_wide[KEY_WIDTH-1:0];

  assign is_ins  = in_data.opcode == slt_pkg::OP_INSERT;
  assign is_del  = in_data.opcode == slt_pkg::OP_DELETE;
  assign is_srch = in_data.opcode == slt_pkg::OP_SEARCH;
  assign is_rew  = in_data.opcode == slt_pkg::OP_REWIND;
  assign is_read = in_data.opcode == slt_pkg::OP_READ;

  assign full     = count == CW'(TABLE_DEPTH);
  assign can_read = cursor < count;

  assign ctrl.ins = take && is_ins && !full;
  assign ctrl.del = take && is_del && found;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      logic signed [KEY_WIDTH-1:0] lk;
      logic                        la;
      logic signed [KEY_WIDTH-1:0] rk;

      assign cell_valid[gi] = CW'(gi) < count;

      if (gi == 0) begin : g_head
        assign lk = '0;
        assign la = 1'b0;
      end else begin : g_body
        assign lk = cell_key[gi-1];
        assign la = cell_flags[gi-1].after;
      end

      if (gi == TABLE_DEPTH - 1) begin : g_tail
        assign rk = cell_key[gi];
      end else begin : g_inner
        assign rk = cell_key[gi+1];
      end

      slt_cell #(
        .KEY_WIDTH(KEY_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .key_arg    (key_arg),
        .left_key   (lk),
        .left_after (la),
        .right_key  (rk),
        .valid      (cell_valid[gi]),
        .key        (cell_key[gi]),
        .flags      (cell_flags[gi])
      );
    end
  endgenerate

  // the first cell not below the argument marks the match point
  always_comb begin
    found     = 1'b0;
    match_pos = '0;
    read_key  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 0) begin
        first_ge[i] = cell_flags[i].ge;
      end else begin
        first_ge[i] = cell_flags[i].ge && !cell_flags[i-1].ge;
      end
      found     = found | (first_ge[i] & cell_flags[i].eq);
      match_pos = match_pos | (first_ge[i] ? IW'(i) : '0);
      read_key  = read_key | ((cursor == CW'(i)) ? cell_key[i] : '0);
    end
  end

  always_comb begin
    count_next  = count;
    cursor_next = cursor;
    status_next = slt_pkg::ST_OK;
    kout_wide   = '0;
    pos_next    = '0;
    if (is_ins) begin
      cursor_next = '0;
      if (full) begin
        status_next = slt_pkg::ST_FULL;
      end else begin
        count_next = count + CW'(1);
      end
    end else if (is_del) begin
      cursor_next = '0;
      if (found) begin
        pos_next   = match_pos;
        count_next = count - CW'(1);
      end else begin
        status_next = slt_pkg::ST_NOT_FOUND;
      end
    end else if (is_srch) begin
      if (found) begin
        pos_next = match_pos;
      end else begin
        status_next = slt_pkg::ST_NOT_FOUND;
      end
    end else if (is_rew) begin
      cursor_next = '0;
    end else if (is_read) begin
      if (can_read) begin
        kout_wide   = 64'(read_key);
        cursor_next = cursor + CW'(1);
      end else begin
        kout_wide   = -64'sd1;
        status_next = slt_pkg::ST_END;
      end
    end
  end

  assign pos_ext   = 64'(pos_next);
  assign count_ext = 64'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        count     <= count_next;
        cursor    <= cursor_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.status      <= status_next;
      out_data.key_out     <= kout_wide[31:0];
      out_data.position    <= pos_ext[3:0];
      out_data.entry_count <= count_ext[4:0];
    end
  end

endmodule

`default_nettype wire
